### hw/rtl/bid_pkg.sv
// ----------------------------------------------------------------------------
// bid_pkg
// Shared types and constants for the four-column block interleaver.
// ----------------------------------------------------------------------------
package bid_pkg;

    // Configuration register file
    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BLOCK_LENGTH_RST = 9'd224;

    // Permutation direction
    localparam logic MODE_INTERLEAVE   = 1'b0;
    localparam logic MODE_DEINTERLEAVE = 1'b1;

    localparam int unsigned NUM_COLS   = 4;
    localparam int unsigned SAMPLE_W   = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Drain side control for one accepted transaction
    typedef struct packed {
        logic rd_en;  // full bank available, read one sample from it
        logic last;   // this read is the final sample of the block
    } t_drain_ctl;

endpackage

### hw/rtl/bid_addr_gen.sv
// ----------------------------------------------------------------------------
// bid_addr_gen
// Block position counter, bank select and four-column address permutation.
// ----------------------------------------------------------------------------
module bid_addr_gen
    import bid_pkg::*;
#(
    parameter int unsigned MAX_BLOCK = 256,
    parameter int unsigned MEM_AW    = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [CFG_DATA_W-1:0] i_block_length,
    input  logic                  i_mode,
    output logic [MEM_AW-1:0]     o_wr_addr,
    output logic [MEM_AW-1:0]     o_rd_addr,
    output t_drain_ctl            o_drain
);

    localparam int unsigned POS_W = (MAX_BLOCK > 2) ? $clog2(MAX_BLOCK) : 2;
    localparam int unsigned LEN_W = $clog2(MAX_BLOCK + 1);
    localparam int unsigned CMP_W = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;
    localparam int unsigned LEN_MAX = (MAX_BLOCK / NUM_COLS) * NUM_COLS;

    logic [POS_W-1:0] r_fill_count, n_fill_count;
    logic             r_fill_bank,  n_fill_bank;
    logic             r_drain_ready, n_drain_ready;

    logic [CFG_DATA_W-1:0] len_masked;
    logic [CMP_W-1:0]      len_cmp;
    logic [LEN_W-1:0]      eff_len;
    logic [POS_W-1:0]      pos;
    logic                  pos_last;
    logic [LEN_W-1:0]      col_len;
    logic [LEN_W+1:0]      perm_full;
    logic [POS_W-1:0]      perm;
    logic [POS_W-1:0]      wr_pos;
    logic [POS_W-1:0]      rd_pos;
    logic                  drain_bank;

    // Clamp the block length to a multiple of four in the supported range
    always_comb begin
        len_masked = {i_block_length[CFG_DATA_W-1:2], 2'b00};
        len_cmp    = CMP_W'(len_masked);
        if (len_cmp < CMP_W'(NUM_COLS)) begin
            eff_len = LEN_W'(NUM_COLS);
        end else if (len_cmp > CMP_W'(LEN_MAX)) begin
            eff_len = LEN_W'(LEN_MAX);
        end else begin
            eff_len = LEN_W'(len_cmp);
        end
    end

    // Restart the block position when the length was shortened past it
    always_comb begin
        if (CMP_W'(r_fill_count) >= CMP_W'(eff_len)) begin
            pos = '0;
        end else begin
            pos = r_fill_count;
        end
        pos_last = (CMP_W'(pos) == CMP_W'(eff_len) - CMP_W'(1));
    end

    // Column-major permutation: (L/4) * (c % 4) + c / 4
    always_comb begin
        col_len   = eff_len >> 2;
        perm_full = (LEN_W+2)'(col_len) * (LEN_W+2)'(pos[1:0])
                  + (LEN_W+2)'(pos >> 2);
        perm      = perm_full[POS_W-1:0];
        if (i_mode == MODE_DEINTERLEAVE) begin
            wr_pos = perm;
            rd_pos = pos;
        end else begin
            wr_pos = pos;
            rd_pos = perm;
        end
    end

    // Map bank and position onto the shared memory
    always_comb begin
        drain_bank = ~r_fill_bank;
        o_wr_addr = MEM_AW'(r_fill_bank) * MEM_AW'(MAX_BLOCK) + MEM_AW'(wr_pos);
        o_rd_addr = MEM_AW'(drain_bank) * MEM_AW'(MAX_BLOCK) + MEM_AW'(rd_pos);
        o_drain.rd_en = r_drain_ready;
        o_drain.last  = pos_last;
    end

    // Advance position; swap banks at the end of a block
    always_comb begin
        n_fill_count  = r_fill_count;
        n_fill_bank   = r_fill_bank;
        n_drain_ready = r_drain_ready;
        if (i_advance) begin
            if (pos_last) begin
                n_fill_count  = '0;
                n_fill_bank   = ~r_fill_bank;
                n_drain_ready = 1'b1;
            end else begin
                n_fill_count  = pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count  <= '0;
            r_fill_bank   <= 1'b0;
            r_drain_ready <= 1'b0;
        end else begin
            r_fill_count  <= n_fill_count;
            r_fill_bank   <= n_fill_bank;
            r_drain_ready <= n_drain_ready;
        end
    end

endmodule

### hw/rtl/bid_bank_mem.sv
// ----------------------------------------------------------------------------
// bid_bank_mem
// Ping-pong sample store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bid_bank_mem
    import bid_pkg::*;
#(
    parameter int unsigned DEPTH  = 512,
    parameter int unsigned MEM_AW = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [MEM_AW-1:0] i_wr_addr,
    input  t_sample           i_wr_data,
    input  logic              i_re,
    input  logic [MEM_AW-1:0] i_rd_addr,
    output t_sample           o_rd_data
);

    t_sample r_mem [DEPTH];
    t_sample r_rd_data;

    // Write the filling bank
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the full bank; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/bid_out_stage.sv
// ----------------------------------------------------------------------------
// bid_out_stage
// Read-data stage plus output register; absorbs receiver stalls.
// ----------------------------------------------------------------------------
module bid_out_stage
    import bid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_last,
    input  t_sample i_rd_data,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_sample o_value,
    output logic    o_last_of_block
);

    logic    r_s1_vld, n_s1_vld;
    logic    r_s1_last;
    logic    r_out_vld, n_out_vld;
    t_sample r_out_value;
    logic    r_out_last;
    logic    out_free;
    logic    s1_move;

    // Move the read stage forward when the output register empties
    always_comb begin
        out_free = !r_out_vld || !i_stall;
        s1_move  = r_s1_vld && out_free;
        o_full   = r_s1_vld && !out_free;
        n_s1_vld = i_load || (r_s1_vld && !s1_move);
        n_out_vld = s1_move || (r_out_vld && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Hold payload alongside the valid flags
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_last <= i_last;
        end
        if (s1_move) begin
            r_out_value <= i_rd_data;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_value         = r_out_value;
    assign o_last_of_block = r_out_last;

endmodule

### hw/rtl/block_interleaver_deinterleaver.sv
// ----------------------------------------------------------------------------
// block_interleaver_deinterleaver
// Double-buffered four-column block interleaver / deinterleaver, 8-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall / i_sample, output channel o_valid /
//   i_stall / o_value / o_last_of_block. A transaction completes on a rising
//   edge with valid high and stall low.
//   Samples fill one bank of block_length entries; the first block gives no
//   output. Each sample of the following block releases one permuted sample
//   of the full bank (interleave: column-major read; deinterleave: scatter
//   write, in-order read), with o_last_of_block on the final one.
//   Throughput is one sample per cycle while o_stall is low, set by the single
//   write and single read port of the bank memory. An output follows the input
//   transaction that releases it through the memory read register, then the
//   output register. A receiver stall holds the output register, and the read
//   stage behind it; o_stall rises only when both are full and i_stall is high.
//   Configuration (i_cfg_we / i_cfg_index / i_cfg_data) is written while idle.
//   Reset clears the block position, bank select, and pipeline flags, and
//   restores block_length 224 and interleave mode; bank contents are kept.
// ----------------------------------------------------------------------------
module block_interleaver_deinterleaver
    import bid_pkg::*;
#(
    parameter int unsigned MAX_BLOCK = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [7:0]      i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [7:0]      o_value,
    output logic                   o_last_of_block
);

    localparam int unsigned MEM_DEPTH = 2 * MAX_BLOCK;
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

    logic [CFG_DATA_W-1:0] r_block_length;
    logic                  r_mode;
    logic                  accept;
    logic                  out_full;
    logic [MEM_AW-1:0]     wr_addr;
    logic [MEM_AW-1:0]     rd_addr;
    t_drain_ctl            drain;
    logic                  rd_load;
    t_sample               rd_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RST;
            r_mode         <= MODE_INTERLEAVE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_LENGTH: begin
                    r_block_length <= i_cfg_data;
                end
                REG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                    r_block_length <= r_block_length;
                end
            endcase
        end
    end

    // Accept a transaction whenever the output side has room
    assign o_stall = out_full;
    assign accept  = i_valid && !out_full;
    assign rd_load = accept && drain.rd_en;

    bid_addr_gen #(
        .MAX_BLOCK (MAX_BLOCK),
        .MEM_AW    (MEM_AW)
    ) u_addr_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (accept),
        .i_block_length (r_block_length),
        .i_mode         (r_mode),
        .o_wr_addr      (wr_addr),
        .o_rd_addr      (rd_addr),
        .o_drain        (drain)
    );

    bid_bank_mem #(
        .DEPTH  (MEM_DEPTH),
        .MEM_AW (MEM_AW)
    ) u_bank_mem (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample),
        .i_re      (rd_load),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bid_out_stage u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (rd_load),
        .i_last          (drain.last),
        .i_rd_data       (rd_data),
        .i_stall         (i_stall),
        .o_full          (out_full),
        .o_valid         (o_valid),
        .o_value         (o_value),
        .o_last_of_block (o_last_of_block)
    );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Block interleaver / deinterleaver testbench
// Drives sample streams through the four-column ping-pong permuter and checks
// every output transaction, value and last-of-block flag, against a
// behavioral model of the banks kept in this file. Covers full-length blocks,
// sample extremes, mode and length changes in the middle of a block, length
// clamping, long receiver back-pressure and randomized block traffic with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import bid_pkg::*;

    localparam int unsigned MAX_BLOCK    = 256;
    localparam int unsigned DRAIN_LAT    = 6;      // cycles to settle after last output
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned HOLD_LEN     = 80;     // long receiver hold-off, in cycles
    localparam int unsigned RUN_LIMIT    = 2000000;

    typedef enum int unsigned {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_style;

    // One permuted sample expected on the output channel
    typedef struct packed {
        t_sample value;
        logic    last;
    } t_permuted;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    t_sample                i_sample;
    logic                   o_valid;
    logic                   i_stall;
    t_sample                o_value;
    logic                   o_last_of_block;

    // Model of the block: configuration, position and both banks
    logic [CFG_DATA_W-1:0] cfg_len;
    logic                  cfg_mode;
    int unsigned           fill_pos;
    bit                    fill_sel;
    bit                    drain_full;
    t_sample               bank_mem [2][MAX_BLOCK];

    t_permuted   permuted_q[$];
    int unsigned n_errors;
    int unsigned burst_left;
    bit          pace_on;
    int unsigned hold_ticket;

    block_interleaver_deinterleaver #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value        (o_value),
        .o_last_of_block(o_last_of_block)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Clear the low two bits and clamp into 4..MAX_BLOCK
    function automatic int unsigned effective_len(logic [CFG_DATA_W-1:0] raw);
        int unsigned n;
        n = raw & ~(CFG_DATA_W'(3));
        if (n < NUM_COLS) n = NUM_COLS;
        if (n > MAX_BLOCK) n = MAX_BLOCK;
        return n;
    endfunction

    // Position of block index c when read column by column
    function automatic int unsigned column_major(int unsigned c, int unsigned n);
        return (n / NUM_COLS) * (c % NUM_COLS) + c / NUM_COLS;
    endfunction

    // Store one accepted sample and queue the sample it releases, if any
    task automatic permute_sample(input t_sample s);
        int unsigned len, c, wr_at, rd_at;
        t_permuted   out;
        len = effective_len(cfg_len);
        if (fill_pos >= len) fill_pos = 0;
        c = fill_pos;
        if (cfg_mode == MODE_DEINTERLEAVE) begin
            wr_at = column_major(c, len);
            rd_at = c;
        end else begin
            wr_at = c;
            rd_at = column_major(c, len);
        end
        if (drain_full) begin
            out.value = bank_mem[!fill_sel][rd_at];
            out.last  = (c == len - 1);
            permuted_q.push_back(out);
        end
        bank_mem[fill_sel][wr_at] = s;
        if (c == len - 1) begin
            fill_pos   = 0;
            fill_sel   = !fill_sel;
            drain_full = 1'b1;
        end else begin
            fill_pos = c + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offer one sample, hold it until accepted, then update the model
    task automatic send_sample(input t_sample s);
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        permute_sample(s);
    endtask

    // Insert a random gap between bursts when pacing is on
    task automatic pace();
        int unsigned gap;
        if (pace_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
    endtask

    task automatic send_random(input int unsigned count);
        t_sample s;
        repeat (count) begin
            pace();
            s = t_sample'($urandom_range(0, 255));
            send_sample(s);
        end
    endtask

    // Stop sending and wait until every queued output has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (permuted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LAT) @(posedge i_clk);
    endtask

    // Write the block length register, then the mode register
    task automatic write_config(input logic [CFG_DATA_W-1:0] len_data,
                                input logic [CFG_DATA_W-1:0] mode_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_BLOCK_LENGTH;
        i_cfg_data  <= len_data;
        @(posedge i_clk);
        cfg_len      = len_data;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= mode_data;
        @(posedge i_clk);
        cfg_mode  = mode_data[0];
        i_cfg_we <= 1'b0;
    endtask

    // Receiver stall pattern, with a long hold-off on request
    initial begin : rx_stall_gen
        int unsigned hold_cnt, style_left, seen_ticket;
        t_rx_style   style;
        hold_cnt    = 0;
        style_left  = 0;
        seen_ticket = 0;
        style       = RX_FREE;
        i_stall    <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seen_ticket != hold_ticket) begin
                seen_ticket = hold_ticket;
                hold_cnt    = HOLD_LEN;
            end
            if (style_left == 0) begin
                style      = t_rx_style'($urandom_range(0, 3));
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            if (hold_cnt != 0) begin
                i_stall <= 1'b1;
                hold_cnt--;
            end else begin
                case (style)
                    RX_FREE:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:  i_stall <= (style_left % 3 == 0);
                endcase
            end
        end
    end

    // Compare each output transaction with the oldest queued sample
    always @(posedge i_clk) begin : check_output
        t_permuted exp_out;
        if (i_rst_n && o_valid && !i_stall) begin
            if (permuted_q.size() == 0) begin
                $error("unexpected output: value %0d last_of_block %0b",
                       o_value, o_last_of_block);
                n_errors++;
            end else begin
                exp_out = permuted_q.pop_front();
                if (o_value !== exp_out.value) begin
                    $error("value mismatch: expected %0d, actual %0d",
                           exp_out.value, o_value);
                    n_errors++;
                end
                if (o_last_of_block !== exp_out.last) begin
                    $error("last_of_block mismatch: expected %0b, actual %0b",
                           exp_out.last, o_last_of_block);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Two full-size blocks and part of a third: first gives nothing, second drains the first.
    // This also writes every entry of both banks.
    task automatic test_full_length();
        wait_drained();
        write_config(CFG_DATA_W'(MAX_BLOCK), CFG_DATA_W'(MODE_INTERLEAVE));
        pace_on = 1'b1;
        send_random(2 * MAX_BLOCK + 16);
    endtask

    // Short block of extreme sample values
    task automatic test_sample_extremes();
        t_sample corner [8];
        corner = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1, 8'sd1, 8'sd85, -8'sd86, 8'sd64};
        wait_drained();
        write_config(CFG_DATA_W'(8), CFG_DATA_W'(MODE_INTERLEAVE));
        pace_on = 1'b0;
        foreach (corner[k]) send_sample(corner[k]);
    endtask

    // Flip the mode in the middle of a block, both ways
    task automatic test_mode_midblock();
        wait_drained();
        write_config(CFG_DATA_W'(8), CFG_DATA_W'(MODE_DEINTERLEAVE));
        send_random(3);
        wait_drained();
        write_config(CFG_DATA_W'(8), CFG_DATA_W'(MODE_INTERLEAVE));
        send_random(2);
    endtask

    // Unaligned length, shortening below the position, clamping both ends
    task automatic test_length_corners();
        wait_drained();
        write_config(CFG_DATA_W'(13), CFG_DATA_W'(MODE_DEINTERLEAVE));
        send_random(5);
        wait_drained();
        write_config(CFG_DATA_W'(2), CFG_DATA_W'(MODE_DEINTERLEAVE));
        send_random(3);
        wait_drained();
        write_config(CFG_DATA_W'(511), CFG_DATA_W'(MODE_INTERLEAVE));
        send_random(2);
    endtask

    // Hold the receiver off while the sender streams without gaps
    task automatic test_backpressure();
        wait_drained();
        write_config(CFG_DATA_W'(16), CFG_DATA_W'(MODE_DEINTERLEAVE));
        pace_on = 1'b0;
        hold_ticket++;
        send_random(48);
        wait_drained();
    endtask

    // Random settings, mostly whole blocks, some cut short
    task automatic test_random();
        int unsigned sent, len, rest, count;
        logic [CFG_DATA_W-1:0] len_data, mode_data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len_data = CFG_DATA_W'(NUM_COLS);
                1:       len_data = CFG_DATA_W'(MAX_BLOCK);
                2, 3:    len_data = CFG_DATA_W'($urandom_range(0, 511));
                default: len_data = CFG_DATA_W'($urandom_range(1, 8) * NUM_COLS);
            endcase
            mode_data = CFG_DATA_W'($urandom_range(0, 511));
            wait_drained();
            write_config(len_data, mode_data);
            len = effective_len(len_data);
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, 2 * len);
            end else begin
                rest  = (fill_pos >= len) ? len : len - fill_pos;
                count = rest + len * ((len > 64) ? 0 : $urandom_range(0, 2));
            end
            pace_on = ($urandom_range(0, 3) != 0);
            send_random(count);
            sent += count;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        n_errors    = 0;
        burst_left  = 0;
        pace_on     = 1'b0;
        hold_ticket = 0;
        cfg_len     = BLOCK_LENGTH_RST;
        cfg_mode    = MODE_INTERLEAVE;
        fill_pos    = 0;
        fill_sel    = 1'b0;
        drain_full  = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_BLOCK_LENGTH;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_length();
        test_sample_extremes();
        test_mode_midblock();
        test_length_corners();
        test_backpressure();
        test_random();
        wait_drained();

        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
